// ----- rtl/mlt_pkg.sv -----
package mlt_pkg;

  // defaults for the top level parameters
  localparam int TABLE_ENTRIES = 64;
  localparam int AGE_BITS      = 16;
  // port numbers at or above this are rejected on learn
  localparam int PORT_COUNT    = 16;

  localparam int MAC_W   = 48;
  localparam int PORT_W  = 4;
  localparam int LIMIT_W = 16;
  localparam int CNT_W   = 7;
  localparam int OP_W    = 2;

  localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = 16'd30;
  localparam logic [CNT_W-1:0]   REMOVED_MAX     = 7'd127;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_LEARN  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  // result of the shared per-entry compare unit
  typedef struct packed {
    logic match;
    logic expire;
  } eval_t;

  // write side controls of the entry store
  typedef struct packed {
    logic we;
    logic set_valid;
    logic clr_valid;
  } st_ctl_t;

endpackage

// ----- rtl/mlt_ifs.sv -----
interface mlt_req_if;
  logic                         valid;
  logic                         ready;
  logic [mlt_pkg::OP_W-1:0]     operation;
  logic [mlt_pkg::MAC_W-1:0]    mac_address;
  logic [mlt_pkg::PORT_W-1:0]   port_number;

  modport source (output valid, output operation, output mac_address, output port_number,
                  input ready);
  modport sink (input valid, input operation, input mac_address, input port_number,
                output ready);
endinterface

interface mlt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [mlt_pkg::PORT_W-1:0]   found_port;
  logic                         learn_dropped;
  logic [mlt_pkg::CNT_W-1:0]    removed_count;

  modport source (output valid, output hit, output found_port, output learn_dropped,
                  output removed_count, input ready);
  modport sink (input valid, input hit, input found_port, input learn_dropped,
                input removed_count, output ready);
endinterface

// ----- rtl/mlt_store.sv -----
module mlt_store #(
  parameter int ENTRIES  = mlt_pkg::TABLE_ENTRIES,
  parameter int AGE_BITS = mlt_pkg::AGE_BITS
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  mlt_pkg::st_ctl_t                                 ctl,
  input  logic [$clog2(ENTRIES)-1:0]                       waddr,
  input  logic [mlt_pkg::MAC_W+mlt_pkg::PORT_W+AGE_BITS-1:0] wdata,
  input  logic [$clog2(ENTRIES)-1:0]                       raddr,
  output logic [mlt_pkg::MAC_W+mlt_pkg::PORT_W+AGE_BITS-1:0] rdata,
  output logic [ENTRIES-1:0]                               valid
);

  localparam int DATA_W = mlt_pkg::MAC_W + mlt_pkg::PORT_W + AGE_BITS;

  logic [DATA_W-1:0] mem [ENTRIES];

  // entry contents: {address, port, age}, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.set_valid) begin
        valid[waddr] <= 1'b1;
      end
      if (ctl.clr_valid) begin
        valid[waddr] <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/mlt_eval.sv -----
module mlt_eval #(
  parameter int AGE_BITS = mlt_pkg::AGE_BITS
) (
  input  logic [mlt_pkg::MAC_W-1:0]   key,
  input  logic [mlt_pkg::MAC_W-1:0]   entry_addr,
  input  logic [AGE_BITS-1:0]         entry_age,
  input  logic [mlt_pkg::LIMIT_W-1:0] age_limit,
  output mlt_pkg::eval_t              res,
  output logic [AGE_BITS-1:0]         age_inc
);

  localparam int CMP_W = (AGE_BITS > mlt_pkg::LIMIT_W) ? AGE_BITS : mlt_pkg::LIMIT_W;

  // saturating age step, then the limit compare on the new age
  always_comb begin
    age_inc    = (&entry_age) ? entry_age : entry_age + AGE_BITS'(1);
    res.match  = (entry_addr == key);
    res.expire = (CMP_W'(age_inc) > CMP_W'(age_limit));
  end

endmodule

// ----- rtl/mlt_seq.sv -----
module mlt_seq #(
  parameter int ENTRIES  = mlt_pkg::TABLE_ENTRIES,
  parameter int AGE_BITS = mlt_pkg::AGE_BITS
) (
  input  logic                                             clk,
  input  logic                                             rst,
  mlt_req_if.sink                                          req,
  mlt_rsp_if.source                                        rsp,
  input  logic [mlt_pkg::LIMIT_W-1:0]                      age_limit,
  output mlt_pkg::st_ctl_t                                 st_ctl,
  output logic [$clog2(ENTRIES)-1:0]                       st_waddr,
  output logic [mlt_pkg::MAC_W+mlt_pkg::PORT_W+AGE_BITS-1:0] st_wdata,
  output logic [$clog2(ENTRIES)-1:0]                       st_raddr,
  input  logic [mlt_pkg::MAC_W+mlt_pkg::PORT_W+AGE_BITS-1:0] st_rdata,
  input  logic [ENTRIES-1:0]                               st_valid
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                  state;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            pidx;
  logic                        pend;

  logic [mlt_pkg::OP_W-1:0]    op;
  logic [mlt_pkg::MAC_W-1:0]   mac;
  logic [mlt_pkg::PORT_W-1:0]  port;
  logic                        noop;
  logic                        hit;
  logic [IDX_W-1:0]            hit_idx;
  logic [mlt_pkg::PORT_W-1:0]  hit_port;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;
  logic [mlt_pkg::CNT_W-1:0]   removed;

  logic [mlt_pkg::MAC_W-1:0]   e_addr;
  logic [mlt_pkg::PORT_W-1:0]  e_port;
  logic [AGE_BITS-1:0]         e_age;
  logic [AGE_BITS-1:0]         age_inc;
  mlt_pkg::eval_t              ev;
  logic                        e_valid;
  logic                        out_free;
  logic                        finish;
  logic                        req_noop;

  assign {e_addr, e_port, e_age} = st_rdata;
  assign e_valid  = st_valid[pidx];
  assign st_raddr = idx;
  assign req.ready = (state == S_IDLE);
  assign out_free = !rsp.valid || rsp.ready;
  assign finish   = (state == S_FIN) && out_free;
  assign req_noop = (req.operation == mlt_pkg::OP_NOP) ||
                    ((req.operation == mlt_pkg::OP_LEARN) &&
                     (int'(req.port_number) >= mlt_pkg::PORT_COUNT));

  mlt_eval #(.AGE_BITS(AGE_BITS)) u_eval (
    .key       (mac),
    .entry_addr(e_addr),
    .entry_age (e_age),
    .age_limit (age_limit),
    .res       (ev),
    .age_inc   (age_inc)
  );

  // store writes: age write-back while a tick sweeps, learn update on finish
  always_comb begin
    st_ctl   = '0;
    st_waddr = pidx;
    st_wdata = {e_addr, e_port, age_inc};
    if (pend && op == mlt_pkg::OP_TICK && e_valid) begin
      st_ctl.we        = 1'b1;
      st_ctl.clr_valid = ev.expire;
    end else if (finish && op == mlt_pkg::OP_LEARN && !noop) begin
      st_wdata = {mac, port, AGE_BITS'(0)};
      if (hit) begin
        st_ctl.we = 1'b1;
        st_waddr  = hit_idx;
      end else if (free_found) begin
        st_ctl.we        = 1'b1;
        st_ctl.set_valid = 1'b1;
        st_waddr         = free_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (finish) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= req_noop ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          pend <= 1'b1;
          if (idx == LAST_IDX) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          pend  <= 1'b0;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // transaction payload, scan bookkeeping and result register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op         <= req.operation;
      mac        <= req.mac_address;
      port       <= req.port_number;
      noop       <= req_noop;
      idx        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      removed    <= '0;
    end
    if (state == S_SCAN) begin
      pidx <= idx;
      idx  <= idx + IDX_W'(1);
    end
    if (pend) begin
      if (e_valid && ev.match && !hit && op != mlt_pkg::OP_TICK) begin
        hit      <= 1'b1;
        hit_idx  <= pidx;
        hit_port <= e_port;
      end
      if (!e_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= pidx;
      end
      if (op == mlt_pkg::OP_TICK && e_valid && ev.expire && removed != mlt_pkg::REMOVED_MAX) begin
        removed <= removed + mlt_pkg::CNT_W'(1);
      end
    end
    if (finish) begin
      rsp.hit           <= hit && !noop &&
                           (op == mlt_pkg::OP_LOOKUP || op == mlt_pkg::OP_LEARN);
      rsp.found_port    <= (hit && op == mlt_pkg::OP_LOOKUP) ? hit_port : '0;
      rsp.learn_dropped <= (op == mlt_pkg::OP_LEARN) && !noop && !hit && !free_found;
      rsp.removed_count <= (op == mlt_pkg::OP_TICK) ? removed : '0;
    end
  end

endmodule

// ----- rtl/mac_learning_table_with_aging_unit.sv -----
// channel  dir  handshake     payload
// req      in   valid/ready   operation, mac_address, port_number
// rsp      out  valid/ready   hit, found_port, learn_dropped, removed_count
// cfg      in   cfg_we        cfg_wdata -> age_limit
//
// Lookup, learn and tick each walk the whole table once, one entry a cycle
// through the single read port of the entry memory; an unused operation or a
// rejected learn skips the walk and goes straight to the result.
// One transaction at a time; req is taken again as soon as the result sits in
// the output register, even while rsp is stalled.
// Synchronous reset empties the table (valid flags) and sets age_limit to 30.
module mac_learning_table_with_aging_unit #(
  parameter int TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES,
  parameter int AGE_BITS      = mlt_pkg::AGE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  mlt_req_if.sink                       req,
  mlt_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [mlt_pkg::LIMIT_W-1:0]   cfg_wdata
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int DATA_W = mlt_pkg::MAC_W + mlt_pkg::PORT_W + AGE_BITS;

  logic [mlt_pkg::LIMIT_W-1:0] age_limit;
  mlt_pkg::st_ctl_t            st_ctl;
  logic [IDX_W-1:0]            st_waddr;
  logic [IDX_W-1:0]            st_raddr;
  logic [DATA_W-1:0]           st_wdata;
  logic [DATA_W-1:0]           st_rdata;
  logic [TABLE_ENTRIES-1:0]    st_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= mlt_pkg::AGE_LIMIT_RESET;
    end else if (cfg_we) begin
      age_limit <= cfg_wdata;
    end
  end

  mlt_store #(.ENTRIES(TABLE_ENTRIES), .AGE_BITS(AGE_BITS)) u_store (
    .clk  (clk),
    .rst  (rst),
    .ctl  (st_ctl),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata),
    .valid(st_valid)
  );

  mlt_seq #(.ENTRIES(TABLE_ENTRIES), .AGE_BITS(AGE_BITS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .age_limit(age_limit),
    .st_ctl   (st_ctl),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .st_raddr (st_raddr),
    .st_rdata (st_rdata),
    .st_valid (st_valid)
  );

endmodule
